FILE: rtl/methylation_site_summarizer_top_defines.svh
// Assertion macros for the methylation site summarizer.
`ifndef METHYLATION_SITE_SUMMARIZER_TOP_DEFINES_SVH
`define METHYLATION_SITE_SUMMARIZER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MSS_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("methylation site summarizer check failed");
`define MSS_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("methylation site summarizer sequence check failed");
`else
`define MSS_ASSERT(lbl, expr)
`define MSS_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

FILE: rtl/mss_pkg.sv
// Shared constants, types and base-letter functions of the methylation site summarizer.
package mss_pkg;

    localparam int COUNT_BITS = 16;
    localparam int DEP_W = COUNT_BITS + 2;
    localparam int TOT_W = COUNT_BITS + 1;
    localparam int Q_W = 14;
    localparam int DIV_W = COUNT_BITS + 15;
    localparam int SCORE_W = 10;
    localparam int SCORE_SCALE = 1000;
    localparam int PCT_SCALE = 20000;
    localparam int DIV_STEPS = Q_W;

    localparam logic [1:0] REG_CANONICAL = 2'd0;
    localparam logic [1:0] REG_KEEP_CPG = 2'd1;
    localparam logic [1:0] REG_KEEP_CHH = 2'd2;
    localparam logic [1:0] REG_KEEP_CHG = 2'd3;

    localparam logic [1:0] CTX_NONE = 2'd0;
    localparam logic [1:0] CTX_CPG = 2'd1;
    localparam logic [1:0] CTX_CHH = 2'd2;
    localparam logic [1:0] CTX_CHG = 2'd3;

    typedef struct packed {
        logic [31:0]            position;
        logic                   strand;
        logic [1:0]             ctx;
        logic [DEP_W-1:0]       depth;
        logic [COUNT_BITS-1:0]  cd;
        logic [COUNT_BITS-1:0]  md;
        logic [COUNT_BITS-1:0]  fd;
        logic [DIV_W-1:0]       rem_s;
        logic [DIV_W-1:0]       dsh_s;
        logic [Q_W-1:0]         q_s;
        logic [DIV_W-1:0]       rem_p;
        logic [DIV_W-1:0]       dsh_p;
        logic [Q_W-1:0]         q_p;
    } div_t;

    function automatic logic [7:0] base_code(input logic [1:0] cb);
        logic [7:0] r;
        case (cb)
            2'd0: r = "A";
            2'd1: r = "C";
            2'd2: r = "G";
            default: r = "T";
        endcase
        return r;
    endfunction

    function automatic logic [7:0] comp_code(input logic [1:0] cb);
        logic [7:0] r;
        case (cb)
            2'd0: r = "T";
            2'd1: r = "G";
            2'd2: r = "C";
            default: r = "A";
        endcase
        return r;
    endfunction

    function automatic logic not_g(input logic [7:0] b);
        return b == "A" || b == "C" || b == "T" || b == "M" || b == "W" || b == "Y"
            || b == "H";
    endfunction

    function automatic logic not_c(input logic [7:0] b);
        return b == "A" || b == "G" || b == "T" || b == "R" || b == "W" || b == "K"
            || b == "D";
    endfunction

endpackage

FILE: rtl/mss_front.sv
// Front stages: strand and context decode, count selection, then divider operand setup.
module mss_front
    import mss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [1:0]            base_sel,
    input  logic                  keep_cpg,
    input  logic                  keep_chh,
    input  logic                  keep_chg,
    input  logic [31:0]           position,
    input  logic [39:0]           ref_window,
    input  logic [COUNT_BITS-1:0] fwd_canonical,
    input  logic [COUNT_BITS-1:0] fwd_modified,
    input  logic [COUNT_BITS-1:0] fwd_filtered,
    input  logic [COUNT_BITS-1:0] fwd_other,
    input  logic [COUNT_BITS-1:0] rev_canonical,
    input  logic [COUNT_BITS-1:0] rev_modified,
    input  logic [COUNT_BITS-1:0] rev_filtered,
    input  logic [COUNT_BITS-1:0] rev_other,
    output logic                  valid,
    output div_t                  data
);

    logic [7:0] m2, m1, c0, p1, p2;
    logic is_fwd, is_rev, is_cpg, is_chh, is_chg, filtering, ctx_ok;
    logic [1:0] ctx;
    logic [COUNT_BITS-1:0] cd, md, fd, od;
    logic [DEP_W-1:0] depth;
    logic [TOT_W-1:0] tot;
    logic keep;

    logic                  v0_reg;
    logic [31:0]           pos0_reg;
    logic                  strand0_reg;
    logic [1:0]            ctx0_reg;
    logic [DEP_W-1:0]      depth0_reg;
    logic [TOT_W-1:0]      tot0_reg;
    logic [COUNT_BITS-1:0] cd0_reg, md0_reg, fd0_reg;

    logic v1_reg;
    div_t d1_reg;
    div_t d1_next;

    always_comb
    begin
        m2 = ref_window[7:0];
        m1 = ref_window[15:8];
        c0 = ref_window[23:16];
        p1 = ref_window[31:24];
        p2 = ref_window[39:32];
        is_fwd = c0 == base_code(base_sel);
        is_rev = !is_fwd && c0 == comp_code(base_sel);
        if (is_fwd)
        begin
            is_cpg = p1 == "G";
            is_chh = not_g(p1) && not_g(p2);
            is_chg = not_g(p1) && p2 == "G";
        end
        else
        begin
            is_cpg = m1 == "C";
            is_chh = not_c(m1) && not_c(m2);
            is_chg = not_c(m1) && m2 == "C";
        end
        filtering = keep_cpg | keep_chh | keep_chg;
        ctx_ok = 1'b1;
        ctx = CTX_NONE;
        if (filtering)
        begin
            if (keep_cpg && is_cpg)
                ctx = CTX_CPG;
            else if (keep_chh && is_chh)
                ctx = CTX_CHH;
            else if (keep_chg && is_chg)
                ctx = CTX_CHG;
            else
                ctx_ok = 1'b0;
        end
        cd = is_fwd ? fwd_canonical : rev_canonical;
        md = is_fwd ? fwd_modified : rev_modified;
        fd = is_fwd ? fwd_filtered : rev_filtered;
        od = is_fwd ? fwd_other : rev_other;
        depth = DEP_W'(cd) + DEP_W'(md) + DEP_W'(fd) + DEP_W'(od);
        tot = TOT_W'(cd) + TOT_W'(md);
        keep = in_valid && (is_fwd || is_rev) && ctx_ok && depth != '0 && tot != '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= keep;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos0_reg <= position;
            strand0_reg <= is_rev;
            ctx0_reg <= ctx;
            depth0_reg <= depth;
            tot0_reg <= tot;
            cd0_reg <= cd;
            md0_reg <= md;
            fd0_reg <= fd;
            d1_reg <= d1_next;
        end
    end

    always_comb
    begin
        d1_next.position = pos0_reg;
        d1_next.strand = strand0_reg;
        d1_next.ctx = ctx0_reg;
        d1_next.depth = depth0_reg;
        d1_next.cd = cd0_reg;
        d1_next.md = md0_reg;
        d1_next.fd = fd0_reg;
        d1_next.rem_s = DIV_W'(tot0_reg) * DIV_W'(SCORE_SCALE);
        d1_next.dsh_s = {depth0_reg, (Q_W-1)'(0)};
        d1_next.q_s = '0;
        d1_next.rem_p = DIV_W'(md0_reg) * DIV_W'(PCT_SCALE) + DIV_W'(tot0_reg);
        d1_next.dsh_p = {tot0_reg, Q_W'(0)};
        d1_next.q_p = '0;
    end

    assign valid = v1_reg;
    assign data = d1_reg;

endmodule

FILE: rtl/mss_div_stage.sv
// One registered restoring-division step for both the score and the percentage quotients.
module mss_div_stage
    import mss_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  div_t in_data,
    output logic out_valid,
    output div_t out_data
);

    logic valid_reg;
    div_t data_reg;
    div_t data_next;
    logic ge_s, ge_p;

    always_comb
    begin
        data_next = in_data;
        ge_s = in_data.rem_s >= in_data.dsh_s;
        ge_p = in_data.rem_p >= in_data.dsh_p;
        data_next.rem_s = ge_s ? in_data.rem_s - in_data.dsh_s : in_data.rem_s;
        data_next.rem_p = ge_p ? in_data.rem_p - in_data.dsh_p : in_data.rem_p;
        data_next.dsh_s = in_data.dsh_s >> 1;
        data_next.dsh_p = in_data.dsh_p >> 1;
        data_next.q_s = {in_data.q_s[Q_W-2:0], ge_s};
        data_next.q_p = {in_data.q_p[Q_W-2:0], ge_p};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

FILE: rtl/methylation_site_summarizer_top.sv
// Top level of the methylation site summarizer pipeline.
// The block takes one pileup column per request on the input channel (in_valid/in_ready)
// and returns at most one site summary per column on the output channel
// (out_valid/out_ready). Columns whose center base matches neither the canonical base
// nor its complement, that fall outside every enabled context, or that have zero depth
// or zero canonical-plus-modified count produce no output and leave a bubble.
// An accepted request passes in order through one decode stage, one
// operand stage with the constant multiplies, and fourteen restoring-division stages
// that produce one quotient bit each for the score and the percentage in parallel.
// A new request can be accepted every cycle while the output is not stalled.
// When out_ready is low while a result waits, the whole pipeline holds and in_ready
// drops; nothing is lost or repeated. Reset clears all valid bits and sets the
// configuration to canonical base C with all context filters off.
// Configuration is written through cfg_we, cfg_index and cfg_data; write it only while idle (not enforced).
module methylation_site_summarizer_top
    import mss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [1:0]            cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [31:0]           position,
    input  logic [39:0]           ref_window,
    input  logic [COUNT_BITS-1:0] fwd_canonical,
    input  logic [COUNT_BITS-1:0] fwd_modified,
    input  logic [COUNT_BITS-1:0] fwd_filtered,
    input  logic [COUNT_BITS-1:0] fwd_other,
    input  logic [COUNT_BITS-1:0] rev_canonical,
    input  logic [COUNT_BITS-1:0] rev_modified,
    input  logic [COUNT_BITS-1:0] rev_filtered,
    input  logic [COUNT_BITS-1:0] rev_other,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           site_position,
    output logic                  strand,
    output logic [1:0]            context_res,
    output logic [DEP_W-1:0]      depth,
    output logic [SCORE_W-1:0]    score,
    output logic [Q_W-1:0]        percent_modified,
    output logic [COUNT_BITS-1:0] canonical_count,
    output logic [COUNT_BITS-1:0] modified_count,
    output logic [COUNT_BITS-1:0] filtered_count
);

`include "methylation_site_summarizer_top_defines.svh"

    logic [1:0] canonical_reg;
    logic keep_cpg_reg, keep_chh_reg, keep_chg_reg;
    logic en;
    logic [DIV_STEPS:0] stage_valid;
    div_t stage_data [DIV_STEPS+1];
    div_t last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canonical_reg <= 2'd1;
            keep_cpg_reg <= 1'b0;
            keep_chh_reg <= 1'b0;
            keep_chg_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CANONICAL: canonical_reg <= cfg_data;
                REG_KEEP_CPG: keep_cpg_reg <= cfg_data[0];
                REG_KEEP_CHH: keep_chh_reg <= cfg_data[0];
                REG_KEEP_CHG: keep_chg_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign en = !stage_valid[DIV_STEPS] || out_ready;
    assign in_ready = en;

    mss_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (in_valid),
        .base_sel       (canonical_reg),
        .keep_cpg       (keep_cpg_reg),
        .keep_chh       (keep_chh_reg),
        .keep_chg       (keep_chg_reg),
        .position       (position),
        .ref_window     (ref_window),
        .fwd_canonical  (fwd_canonical),
        .fwd_modified   (fwd_modified),
        .fwd_filtered   (fwd_filtered),
        .fwd_other      (fwd_other),
        .rev_canonical  (rev_canonical),
        .rev_modified   (rev_modified),
        .rev_filtered   (rev_filtered),
        .rev_other      (rev_other),
        .valid          (stage_valid[0]),
        .data           (stage_data[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        mss_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (stage_valid[i]),
            .in_data   (stage_data[i]),
            .out_valid (stage_valid[i+1]),
            .out_data  (stage_data[i+1])
        );
    end

    assign last = stage_data[DIV_STEPS];
    assign out_valid = stage_valid[DIV_STEPS];
    assign site_position = last.position;
    assign strand = last.strand;
    assign context_res = last.ctx;
    assign depth = last.depth;
    assign score = last.q_s[SCORE_W-1:0];
    assign percent_modified = last.q_p;
    assign canonical_count = last.cd;
    assign modified_count = last.md;
    assign filtered_count = last.fd;

    `MSS_ASSERT(a_score_range, !out_valid || score <= SCORE_W'(SCORE_SCALE))
    `MSS_ASSERT(a_nonzero_depth, !out_valid || (depth != '0 && last.q_s[Q_W-1:SCORE_W] == '0))
    `MSS_ASSERT(a_pct_range, !out_valid || percent_modified <= Q_W'(10000))
    `MSS_ASSERT_NEXT(a_hold_on_stall, out_valid && !out_ready, out_valid && !in_ready == !out_ready)

endmodule
